[design/kss_pkg.sv]
// Shared widths and the per-cell control bundle for the streaming k-th smallest selector.
package kss_pkg;

	// Fixed field widths of the item and result beats
	localparam int RANK_BITS = 5;
	localparam int REF_BITS  = 32;
	localparam int WORD_BITS = 32;

	// Reset value of the rank register
	localparam logic [RANK_BITS-1:0] RANK_RESET = RANK_BITS'(1);

	// Control that the top level hands to every cell in a cycle
	typedef struct packed {
		logic accept;    // an input beat is taken this cycle
		logic last;      // that beat closes the list
		logic enter;     // the new item goes into the kept set
		logic in_rank;   // this cell sits below the current rank
		logic take_new;  // this cell is the insertion point if it moves
	} kss_ctl_t;

endpackage

[design/kth_smallest_stream_select.sv]
// Streaming k-th smallest selector: top level with the cell chain, rank register and result stage.
// Takes one item beat per clock and keeps the kth_rank smallest items of the current list in a
// sorted chain of K_MAX cells; each beat is compared against every cell and inserted in the same
// cycle, so the sustained rate is one item per cycle when not stalled, set by the compare-and-insert
// across the chain. The result beat for an item marked last_item appears on the output register
// in the cycle after that item is taken. Equal weights rank by arrival, earlier first. If the list
// held fewer than kth_rank items, short_list is set and the largest kept item is returned.
// kth_rank of 0 acts as 1 and values above K_MAX act as K_MAX. The input stalls only while a
// finished result waits to be taken.
module kth_smallest_stream_select #(
	parameter int K_MAX       = 16,
	parameter int WEIGHT_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// rank register write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [kss_pkg::RANK_BITS-1:0]   kth_rank,
	// item channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [kss_pkg::WORD_BITS-1:0]   edge_weight,
	input  logic [kss_pkg::REF_BITS-1:0]    edge_ref,
	input  logic                            last_item,
	// result channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [kss_pkg::WORD_BITS-1:0]   kth_weight,
	output logic [kss_pkg::REF_BITS-1:0]    kth_ref,
	output logic                            short_list
);

	localparam int KW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
	localparam int CB  = ($clog2(K_MAX + 1) > kss_pkg::RANK_BITS) ?
	                     $clog2(K_MAX + 1) : kss_pkg::RANK_BITS;

	logic [kss_pkg::RANK_BITS-1:0] rank_q;
	logic [CB-1:0]                 rank_c;
	logic [KW-1:0]                 km1;

	logic                          accept;
	logic                          enter;
	logic [WEIGHT_BITS-1:0]        w_in;

	logic [K_MAX-1:0]              act;
	logic [K_MAX-1:0]              le;
	logic [K_MAX-1:0]              in_rank;
	logic [K_MAX-1:0]              nv;
	logic [K_MAX-1:0]              sel;
	logic [WEIGHT_BITS-1:0]        cw   [K_MAX];
	logic [kss_pkg::REF_BITS-1:0]  cr   [K_MAX];
	logic [WEIGHT_BITS-1:0]        nw   [K_MAX];
	logic [kss_pkg::REF_BITS-1:0]  nr   [K_MAX];

	logic [WEIGHT_BITS-1:0]        pick_w;
	logic [kss_pkg::REF_BITS-1:0]  pick_r;

	logic                          out_valid_q;
	logic [kss_pkg::WORD_BITS-1:0] kth_weight_q;
	logic [kss_pkg::REF_BITS-1:0]  kth_ref_q;
	logic                          short_list_q;

	// Rank register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= kss_pkg::RANK_RESET;
		end else if (cfg_valid && cfg_ready) begin
			rank_q <= kth_rank;
		end
	end

	// Clamp rank to 1..K_MAX and form the index of the k-th slot
	always_comb begin
		rank_c = CB'(rank_q);
		if (rank_c == '0) begin
			rank_c = CB'(1);
		end
		if (rank_c > CB'(K_MAX)) begin
			rank_c = CB'(K_MAX);
		end
		km1 = KW'(rank_c - CB'(1));
	end

	// Handshake: take items unless a finished result is stuck
	assign in_ready = ~out_valid_q | out_ready;
	assign accept   = in_valid & in_ready;
	assign w_in     = WEIGHT_BITS'(edge_weight);

	// New item enters unless the k-th slot is full and not above it
	assign enter = ~le[km1];

	// Cell chain
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		kss_pkg::kss_ctl_t ctl;

		assign in_rank[i]  = (KW'(i) <= km1);
		assign ctl.accept  = accept;
		assign ctl.last    = last_item;
		assign ctl.enter   = enter;
		assign ctl.in_rank = in_rank[i];

		if (i == 0) begin : g_head
			assign ctl.take_new = 1'b1;
			kss_cell #(.WB(WEIGHT_BITS)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_weight  (w_in),
				.new_ref     (edge_ref),
				.prev_act    (1'b0),
				.prev_weight (w_in),
				.prev_ref    (edge_ref),
				.act         (act[i]),
				.le          (le[i]),
				.weight      (cw[i]),
				.ref_out     (cr[i]),
				.nxt_valid   (nv[i]),
				.nxt_weight  (nw[i]),
				.nxt_ref     (nr[i])
			);
		end else begin : g_body
			assign ctl.take_new = le[i-1];
			kss_cell #(.WB(WEIGHT_BITS)) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_weight  (w_in),
				.new_ref     (edge_ref),
				.prev_act    (act[i-1]),
				.prev_weight (cw[i-1]),
				.prev_ref    (cr[i-1]),
				.act         (act[i]),
				.le          (le[i]),
				.weight      (cw[i]),
				.ref_out     (cr[i]),
				.nxt_valid   (nv[i]),
				.nxt_weight  (nw[i]),
				.nxt_ref     (nr[i])
			);
		end
	end

	// Last valid slot after insertion: k-th slot, or the largest item on a short list
	always_comb begin
		for (int i = 0; i < K_MAX - 1; i++) begin
			sel[i] = nv[i] & ~nv[i+1];
		end
		sel[K_MAX-1] = nv[K_MAX-1];
	end

	always_comb begin
		pick_w = '0;
		pick_r = '0;
		for (int i = 0; i < K_MAX; i++) begin
			pick_w = pick_w | (nw[i] & {WEIGHT_BITS{sel[i]}});
			pick_r = pick_r | (nr[i] & {kss_pkg::REF_BITS{sel[i]}});
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && last_item) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last_item) begin
			kth_weight_q <= kss_pkg::WORD_BITS'(pick_w);
			kth_ref_q    <= pick_r;
			short_list_q <= ~nv[km1];
		end
	end

	assign out_valid  = out_valid_q;
	assign kth_weight = kth_weight_q;
	assign kth_ref    = kth_ref_q;
	assign short_list = short_list_q;

	// Counting slots always form an unbroken run from the head
	a_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((act >> 1) & ~act) == '0)
		else $error("kept slots not contiguous");

	// A closing item always produces a result beat next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_item) |=> out_valid)
		else $error("closing item gave no result");

	// The chain is empty after a list closes
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_item) |=> (act == '0))
		else $error("chain not cleared after last item");

	// Kept weights stay in ascending order
	for (genvar j = 1; j < K_MAX; j++) begin : g_order
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			act[j] |-> (cw[j-1] <= cw[j]))
			else $error("kept weights out of order");
	end

endmodule

[design/kss_cell.sv]
// One sorted slot of the insertion chain: holds an item, compares, and takes from its left neighbor.
module kss_cell #(
	parameter int WB = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kss_pkg::kss_ctl_t             ctl,
	input  logic [WB-1:0]                 new_weight,
	input  logic [kss_pkg::REF_BITS-1:0]  new_ref,
	input  logic                          prev_act,
	input  logic [WB-1:0]                 prev_weight,
	input  logic [kss_pkg::REF_BITS-1:0]  prev_ref,
	output logic                          act,
	output logic                          le,
	output logic [WB-1:0]                 weight,
	output logic [kss_pkg::REF_BITS-1:0]  ref_out,
	output logic                          nxt_valid,
	output logic [WB-1:0]                 nxt_weight,
	output logic [kss_pkg::REF_BITS-1:0]  nxt_ref
);

	logic                         valid_q;
	logic [WB-1:0]                weight_q;
	logic [kss_pkg::REF_BITS-1:0] ref_q;

	// Slot counts only while it lies below the rank; ties keep earlier arrivals first
	assign act     = valid_q & ctl.in_rank;
	assign le      = act & (weight_q <= new_weight);
	assign weight  = weight_q;
	assign ref_out = ref_q;

	// Next content: hold, take the new item, or shift in from the left
	always_comb begin
		nxt_weight = weight_q;
		nxt_ref    = ref_q;
		nxt_valid  = act;
		priority if (!ctl.in_rank) begin
			nxt_valid = 1'b0;
		end else if (!ctl.enter || le) begin
			nxt_valid = act;
		end else if (ctl.take_new) begin
			nxt_weight = new_weight;
			nxt_ref    = new_ref;
			nxt_valid  = 1'b1;
		end else begin
			nxt_weight = prev_weight;
			nxt_ref    = prev_ref;
			nxt_valid  = prev_act;
		end
	end

	// Valid clears at the end of each list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.accept) begin
			valid_q <= nxt_valid & ~ctl.last;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			weight_q <= nxt_weight;
			ref_q    <= nxt_ref;
		end
	end

endmodule
